FILE: rtl/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: double-ended queue package
// Sizes, operation and status codes, and the request and response payloads.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Storage sizes
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Fixed payload field widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCC_W   = 5;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    func_e             func;
    logic [VAL_W-1:0]  push_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  pop_value;
    status_e           status;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

endpackage

FILE: rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque on a circular store
// Push/pop at either end or clear; one response per request with the popped
// value, a status code and the occupancy after the request.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   request | in        | in_valid_i / in_ready_o | in_req_i  (dq_pkg::req_t)
//   result  | out       | out_valid_o/out_ready_i | out_rsp_o (dq_pkg::rsp_t)
//
// One request per cycle sustained while results are taken; its response is
// loaded into the store read and pending stage at the transfer, then into
// the output register.
// Pointer and count update at the request transfer, so requests never wait
// on each other; only the output register limits the rate.
// Reset empties the queue at once: no clearing pass, store contents unused.
// A stalled result holds the request stage; a new request is taken whenever
// the pending stage is empty or moves on to the output register that cycle.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dq_pkg::req_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dq_pkg::rsp_t  out_rsp_o
);

  import dq_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Queue state
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Entry store: one write and one registered read per cycle
  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [VALUE_BITS-1:0] wr_data, rd_data_q;

  // Pending stage: waits for the read data
  logic             s1_valid_q;
  logic             s1_pop_q,    s1_pop_d;
  status_e          s1_status_q, s1_status_d;
  logic [CNT_W-1:0] s1_count_q;

  // Output register
  logic out_valid_q;
  rsp_t out_q;

  logic in_xfer, s1_move;

  // Ring index arithmetic; sums stay below twice the depth
  logic [IDX_W:0]   back_sum, last_sum;
  logic [IDX_W-1:0] back_idx, last_idx, front_dec, front_inc;
  logic             is_full, is_empty;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign is_full  = (count_q >= FULL_CNT);
  assign is_empty = (count_q == '0);

  // front + count: slot after the back entry
  assign back_sum = {1'b0, front_q} + (IDX_W + 1)'(count_q);
  assign back_idx = (back_sum >= (IDX_W + 1)'(DEPTH)) ?
                    IDX_W'(back_sum - (IDX_W + 1)'(DEPTH)) : IDX_W'(back_sum);
  // front + count - 1: the back entry itself
  assign last_sum = back_sum - (IDX_W + 1)'(1);
  assign last_idx = (last_sum >= (IDX_W + 1)'(DEPTH)) ?
                    IDX_W'(last_sum - (IDX_W + 1)'(DEPTH)) : IDX_W'(last_sum);

  assign front_dec = (front_q == '0)      ? LAST_IDX : front_q - IDX_W'(1);
  assign front_inc = (front_q == LAST_IDX) ? '0      : front_q + IDX_W'(1);

  assign wr_data = VALUE_BITS'(in_req_i.push_value);

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    wr_en       = 1'b0;
    wr_addr     = back_idx;
    rd_en       = 1'b0;
    rd_addr     = front_q;
    s1_pop_d    = 1'b0;
    s1_status_d = ST_OK;
    if (in_xfer) begin
      case (in_req_i.func)
        OP_PUSH_FRONT: begin
          if (is_full) begin
            s1_status_d = ST_FULL;
          end else begin
            front_d = front_dec;
            count_d = count_q + CNT_W'(1);
            wr_en   = 1'b1;
            wr_addr = front_dec;
          end
        end
        OP_PUSH_BACK: begin
          if (is_full) begin
            s1_status_d = ST_FULL;
          end else begin
            count_d = count_q + CNT_W'(1);
            wr_en   = 1'b1;
            wr_addr = back_idx;
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            s1_status_d = ST_EMPTY;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = front_q;
            s1_pop_d = 1'b1;
            front_d  = front_inc;
            count_d  = count_q - CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            s1_status_d = ST_EMPTY;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = last_idx;
            s1_pop_d = 1'b1;
            count_d  = count_q - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          front_d = '0;
          count_d = '0;
        end
        default: begin
          // unused codes: no operation
        end
      endcase
    end
  end

  // Store: write lands before a read of the same entry in the next cycle,
  // and the two never target one entry in the same cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pop_q    <= s1_pop_d;
      s1_status_q <= s1_status_d;
      s1_count_q  <= count_d;
    end
    if (s1_move) begin
      out_q.pop_value <= s1_pop_q ? VAL_W'(rd_data_q) : '0;
      out_q.status    <= s1_status_q;
      out_q.occupancy <= OCC_W'(s1_count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for double_ended_queue
// Drives push/pop/clear requests at both ends and mirrors the deque in a
// local model. Every response transfer is compared field by field with the
// oldest predicted response. Sender bursts, receiver stall patterns and
// one long receiver hold-off exercise the valid/ready handshakes.
// ----------------------------------------------------------------------------
module tb_top;
  import dq_pkg::*;

  // Reserved request codes: the block must treat them as no-ops
  localparam logic [FUNC_W-1:0] FUNC_RSVD_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_LAST  = 3'd7;

  localparam logic [VAL_W-1:0] VALUE_MASK =
    (VALUE_BITS >= VAL_W) ? '1 : VAL_W'((64'd1 << VALUE_BITS) - 64'd1);

  localparam int unsigned CLK_PERIOD      = 8;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned HOLD_OFF_CYCLES = 96;    // long receiver stall
  localparam int unsigned IDLE_LIMIT      = 1000;  // cycles with no transfer
  localparam int unsigned DRAIN_CYCLES    = 16;    // settle after last result
  localparam int unsigned MAX_PRINTS      = 40;

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;

  double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Deque mirror: circular store, front index and fill count, updated at
  // each request transfer in the order the block sees them.
  // --------------------------------------------------------------------------
  logic [VAL_W-1:0] mirror_slots [DEPTH];
  int unsigned      mirror_head = 0;
  int unsigned      mirror_fill = 0;

  rsp_t        expected_rsp_q [$];   // responses still owed by the block
  int unsigned mismatch_count = 0;
  int unsigned req_count      = 0;   // request transfers so far

  // Sender pacing: bursts of up to burst_max transfers, then a gap of up
  // to gap_max cycles with valid low. gap_max of 0 means back-to-back.
  int unsigned burst_max  = 8;
  int unsigned gap_max    = 4;
  int unsigned burst_left = 1;

  // Set by a test to make the receiver stall for HOLD_OFF_CYCLES
  bit hold_off_req = 1'b0;

  function automatic rsp_t predict_deque_rsp(req_t req);
    rsp_t        rsp;
    int unsigned slot;
    rsp.pop_value = '0;
    rsp.status    = ST_OK;
    case (req.func)
      OP_PUSH_FRONT: begin
        if (mirror_fill >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
          mirror_slots[mirror_head] = req.push_value & VALUE_MASK;
          mirror_fill++;
        end
      end
      OP_PUSH_BACK: begin
        if (mirror_fill >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          slot = (mirror_head + mirror_fill) % DEPTH;
          mirror_slots[slot] = req.push_value & VALUE_MASK;
          mirror_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (mirror_fill == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.pop_value = mirror_slots[mirror_head];
          mirror_head   = (mirror_head + 1) % DEPTH;
          mirror_fill--;
        end
      end
      OP_POP_BACK: begin
        if (mirror_fill == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          slot = (mirror_head + mirror_fill - 1) % DEPTH;
          rsp.pop_value = mirror_slots[slot];
          mirror_fill--;
        end
      end
      OP_CLEAR: begin
        mirror_fill = 0;
        mirror_head = 0;
      end
      default: ;  // reserved codes leave the deque alone
    endcase
    rsp.occupancy = OCC_W'(mirror_fill);
    return rsp;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // --------------------------------------------------------------------------
  // Request side. Valid goes high with the payload and stays there until the
  // transfer; it only drops between bursts, so back-to-back requests never
  // see valid lowered and raised in one step.
  // --------------------------------------------------------------------------
  task automatic send_request(func_e op, logic [VAL_W-1:0] value);
    req_t        req;
    int unsigned gap;
    req.func       = op;
    req.push_value = value;
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rsp_q.push_back(predict_deque_rsp(req));
    req_count++;
    burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, burst_max);
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VAL_W'($urandom);
  endfunction

  // Mixed request code, reserved codes included at a low rate
  function automatic func_e pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 22) return OP_PUSH_FRONT;
    if (r < 44) return OP_PUSH_BACK;
    if (r < 66) return OP_POP_FRONT;
    if (r < 88) return OP_POP_BACK;
    if (r < 93) return OP_CLEAR;
    return func_e'(FUNC_W'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST)));
  endfunction

  // --------------------------------------------------------------------------
  // Response side: the receiver switches between stall patterns every so
  // often; a hold-off request overrides it with one long stall.
  // --------------------------------------------------------------------------
  initial begin : rsp_stall
    int unsigned mode;
    int unsigned span;
    logic [7:0]  pattern;
    wait (rst_ni);
    forever begin
      mode    = $urandom_range(0, 3);
      span    = $urandom_range(20, 200);
      pattern = 8'($urandom) | 8'h01;
      repeat (span) begin
        @(posedge clk_i);
        if (hold_off_req) begin
          out_ready_i <= 1'b0;
          repeat (HOLD_OFF_CYCLES - 1) @(posedge clk_i);
          hold_off_req = 1'b0;
        end else begin
          case (mode)
            0: out_ready_i <= 1'b1;                          // no stalls
            1: out_ready_i <= ($urandom_range(0, 99) < 65);  // heavy random
            2: begin                                         // rotating mask
              out_ready_i <= pattern[0];
              pattern = {pattern[0], pattern[7:1]};
            end
            default: out_ready_i <= ($urandom_range(0, 9) != 0);
          endcase
        end
      end
    end
  end

  // Compare every response transfer with the oldest prediction
  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected response %p", out_rsp_o));
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_rsp_o.pop_value !== want.pop_value)
          report_mismatch($sformatf("pop_value got %h want %h",
                                    out_rsp_o.pop_value, want.pop_value));
        if (out_rsp_o.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_rsp_o.status, want.status));
        if (out_rsp_o.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy got %0d want %0d",
                                    out_rsp_o.occupancy, want.occupancy));
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for a
  // long while (a hung handshake or a lost response).
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Edge cases: extreme values, both ends, full, empty, clear, reserved codes
  task automatic test_directed();
    int i;
    burst_max = 4;
    gap_max   = 3;
    send_request(OP_PUSH_FRONT, '0);
    send_request(OP_PUSH_BACK, '1);
    // fill to DEPTH, alternating ends so the front index wraps below zero
    for (i = 2; i < DEPTH; i++) begin
      send_request((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                   (i % 2) ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i);
    end
    send_request(OP_PUSH_FRONT, 32'hDEAD_0001);  // dropped, full
    send_request(OP_PUSH_BACK, 32'hDEAD_0002);   // dropped, full
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_CLEAR, '1);                  // clear with entries held
    send_request(OP_POP_FRONT, '1);              // pop on empty
    send_request(OP_POP_BACK, '1);
    for (i = FUNC_RSVD_FIRST; i <= FUNC_RSVD_LAST; i++) begin
      send_request(func_e'(FUNC_W'(i)), '1);
    end
  endtask

  // Unstructured random requests
  task automatic test_random_mix(int unsigned n_items);
    int unsigned i;
    burst_max = $urandom_range(1, 16);
    gap_max   = $urandom_range(0, 6);
    for (i = 0; i < n_items; i++) begin
      if (i % 100 == 99) begin
        burst_max = $urandom_range(1, 16);
        gap_max   = $urandom_range(0, 6);
      end
      send_request(pick_func(), pick_value());
    end
  endtask

  // Fill/drain runs at random ends: reaches full and empty often and walks
  // the front index around the ring; a little noise is mixed in.
  task automatic test_fill_drain(int unsigned n_items);
    int unsigned stop_at;
    int unsigned n_push;
    int unsigned n_pop;
    int unsigned k;
    func_e       op;
    stop_at = req_count + n_items;
    while (req_count < stop_at) begin
      burst_max = $urandom_range(1, 24);
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      n_push = $urandom_range(1, DEPTH + 3);
      for (k = 0; k < n_push; k++) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if ($urandom_range(0, 99) < 8) op = pick_func();
        send_request(op, pick_value());
      end
      n_pop = $urandom_range(1, DEPTH + 3);
      for (k = 0; k < n_pop; k++) begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        if ($urandom_range(0, 99) < 8) op = pick_func();
        send_request(op, pick_value());
      end
      if ($urandom_range(0, 9) == 0) send_request(OP_CLEAR, pick_value());
    end
  endtask

  // Receiver holds off while the sender keeps offering back-to-back, so the
  // block fills its output path and drops in_ready_o.
  task automatic test_backpressure(int unsigned n_items);
    int unsigned i;
    burst_max    = n_items;
    gap_max      = 0;
    burst_left   = n_items;
    hold_off_req = 1'b1;
    for (i = 0; i < n_items; i++) begin
      send_request(pick_func(), pick_value());
    end
  endtask

  initial begin : main
    for (int i = 0; i < DEPTH; i++) mirror_slots[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix(400);
    test_fill_drain(600);
    test_backpressure(60);
    test_random_mix(60);

    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
